// ===== rtl/core/ppd_pkg.sv =====
package ppd_pkg;

   // multiplier digit size, one hard multiplier per digit pair
   localparam int MUL_DIGIT     = 32;
   localparam int MUL_DIGIT_LOG = 5;

   localparam int DIST_WIDTH = 31;
   localparam int FOOT_WIDTH = 32;

   localparam logic [DIST_WIDTH-1:0]        DIST_MAX = '1;
   localparam logic signed [FOOT_WIDTH-1:0] FOOT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [FOOT_WIDTH-1:0] FOOT_MIN = 32'sh80000000;

   // digits of MUL_DIGIT bits needed for a w-bit magnitude
   function automatic int mul_digits(input int w);
      return (w + MUL_DIGIT - 1) >> MUL_DIGIT_LOG;
   endfunction

   // natural stage count of ppd_mul: magnitude stage plus one stage per digit pair
   function automatic int mul_lat(input int wa, input int wb);
      return mul_digits(wa) * mul_digits(wb) + 1;
   endfunction

endpackage

// ===== rtl/core/point_plane_distance_and_foot.sv =====
// point to plane distance and perpendicular foot, exact fixed point
//
// each word carries plane points a, b, c and query point x as signed fixed
// point coordinates of COORD_WIDTH bits (Q16.16 at 32 bits; all values share
// one scale). the normal N = (b-a) x (c-a), v = x-a, P = N.v and Q = N.N are
// formed exactly. results:
//   plane_distance   = min(floor(|P| / sqrt(Q)), 2^31-1)
//   foot_i           = sat32(x_i - trunc(N_i * P / Q))
//   degenerate_plane = 1 when N is zero; then distance 0 and foot = x
//
// rate: one word per cycle, sustained while no result is held at the
// output. the pipeline length PIPE_LEN is set by the digit serial
// multipliers (one 32x32 digit product per stage), the restoring dividers
// (one quotient bit per stage, 2*COORD_WIDTH+2 for the distance) and the
// square root (one root bit per stage).
// the whole pipeline advances together: req_ready = !rsp_valid || rsp_ready,
// so a held result freezes every stage and nothing is dropped or repeated.
// no state survives between words; reset only clears the valid bits.
module point_plane_distance_and_foot import ppd_pkg::*; #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_plane_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_plane_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_plane_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_plane_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_plane_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_plane_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_plane_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_plane_c_y,
   input  logic signed [COORD_WIDTH-1:0] req_plane_c_z,
   input  logic signed [COORD_WIDTH-1:0] req_query_x,
   input  logic signed [COORD_WIDTH-1:0] req_query_y,
   input  logic signed [COORD_WIDTH-1:0] req_query_z,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [DIST_WIDTH-1:0]         rsp_plane_distance,
   output logic signed [FOOT_WIDTH-1:0]  rsp_foot_x,
   output logic signed [FOOT_WIDTH-1:0]  rsp_foot_y,
   output logic signed [FOOT_WIDTH-1:0]  rsp_foot_z,
   output logic                          rsp_degenerate_plane
);

   // widths of the exact intermediates
   localparam int W     = COORD_WIDTH;
   localparam int E     = W + 1;            // edges and v
   localparam int WN    = 2 * E + 1;        // normal components
   localparam int PTW   = WN + E + 1;       // one signed term of N.v
   localparam int WP    = PTW + 2;          // P
   localparam int WQS   = 2 * WN + 2;       // Q
   localparam int WR    = W + 1;            // square root bits
   localparam int LD    = 2 * WR;           // distance quotient bits, P*P/Q <= |v|^2
   localparam int LF    = W + 1;            // foot quotient bits, |N_i P|/Q <= |v|
   localparam int SW    = 2 * WR + 1;
   localparam int FW    = (W + 3 > FOOT_WIDTH + 1) ? W + 3 : FOOT_WIDTH + 1;
   localparam int DW    = (WR > DIST_WIDTH) ? WR + 1 : DIST_WIDTH + 1;

   // stage counts of each section
   localparam int LAT1  = mul_lat(E, E);
   localparam int LAT2  = mul_lat(WN, WN);
   localparam int LAT3  = mul_lat(WP, WP);
   localparam int EXTRA = LD + WR - LF;
   localparam int VD    = LAT1 + 1;
   localparam int ND    = LAT2 + 2;
   localparam int GD    = LAT3 + LD + WR;
   localparam int SD    = LF + EXTRA;
   localparam int XD    = LAT1 + 1 + LAT2 + 2 + GD;
   localparam int PIPE_LEN = XD + 2;

   localparam logic signed [FW-1:0] F_HI = FW'(FOOT_MAX);
   localparam logic signed [FW-1:0] F_LO = FW'(FOOT_MIN);

   logic                en;
   logic [PIPE_LEN-1:0] vld_ff;

   // global advance: output register free or being drained
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_LEN-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LEN-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------- stage a
   // edges, v and the query point
   logic [2:0][E-1:0] e1_ff, e2_ff, v_ff;
   logic [2:0][W-1:0] x_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff[0] <= E'(req_plane_b_x) - E'(req_plane_a_x);
         e1_ff[1] <= E'(req_plane_b_y) - E'(req_plane_a_y);
         e1_ff[2] <= E'(req_plane_b_z) - E'(req_plane_a_z);
         e2_ff[0] <= E'(req_plane_c_x) - E'(req_plane_a_x);
         e2_ff[1] <= E'(req_plane_c_y) - E'(req_plane_a_y);
         e2_ff[2] <= E'(req_plane_c_z) - E'(req_plane_a_z);
         v_ff[0]  <= E'(req_query_x) - E'(req_plane_a_x);
         v_ff[1]  <= E'(req_query_y) - E'(req_plane_a_y);
         v_ff[2]  <= E'(req_query_z) - E'(req_plane_a_z);
         x_ff[0]  <= req_query_x;
         x_ff[1]  <= req_query_y;
         x_ff[2]  <= req_query_z;
      end
   end

   // --------------------------------------------------------- cross product
   logic [2:0][2*E-1:0] cl_mag, cr_mag;
   logic [2:0]          cl_neg, cr_neg;

   for (genvar i = 0; i < 3; i++) begin : g_cross
      ppd_mul #(.A_W(E), .B_W(E), .STAGES(LAT1)) u_mul_l (
         .clock    (clock),
         .en       (en),
         .a        (e1_ff[(i+1)%3]),
         .b        (e2_ff[(i+2)%3]),
         .prod_mag (cl_mag[i]),
         .prod_neg (cl_neg[i])
      );
      ppd_mul #(.A_W(E), .B_W(E), .STAGES(LAT1)) u_mul_r (
         .clock    (clock),
         .en       (en),
         .a        (e1_ff[(i+2)%3]),
         .b        (e2_ff[(i+1)%3]),
         .prod_mag (cr_mag[i]),
         .prod_neg (cr_neg[i])
      );
   end

   // v waits for the normal
   logic [2:0][E-1:0] vd_ff [VD];

   always_ff @(posedge clock) begin
      if (en) begin
         vd_ff[0] <= v_ff;
         for (int k = 1; k < VD; k++) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stage b
   // normal from signed cross terms
   logic [2:0][WN-1:0] n_in, n_ff;

   always_comb begin
      logic [WN-1:0] lv, rv;
      lv = '0;
      rv = '0;
      for (int i = 0; i < 3; i++) begin
         lv      = WN'(cl_mag[i]);
         rv      = WN'(cr_mag[i]);
         n_in[i] = (cl_neg[i] ? -lv : lv) - (cr_neg[i] ? -rv : rv);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
      end
   end

   // --------------------------------------------------- N.v and N.N terms
   logic [2:0][WN+E-1:0] pm_mag;
   logic [2:0]           pm_neg;
   logic [2:0][2*WN-1:0] qm_mag;

   for (genvar i = 0; i < 3; i++) begin : g_dot
      ppd_mul #(.A_W(WN), .B_W(E), .STAGES(LAT2)) u_mul_p (
         .clock    (clock),
         .en       (en),
         .a        (n_ff[i]),
         .b        (vd_ff[VD-1][i]),
         .prod_mag (pm_mag[i]),
         .prod_neg (pm_neg[i])
      );
      ppd_mul #(.A_W(WN), .B_W(WN), .STAGES(LAT2)) u_mul_q (
         .clock    (clock),
         .en       (en),
         .a        (n_ff[i]),
         .b        (n_ff[i]),
         .prod_mag (qm_mag[i]),
         .prod_neg ()
      );
   end

   // normal waits for P
   logic [2:0][WN-1:0] nd_ff [ND];

   always_ff @(posedge clock) begin
      if (en) begin
         nd_ff[0] <= n_ff;
         for (int k = 1; k < ND; k++) begin
            nd_ff[k] <= nd_ff[k-1];
         end
      end
   end

   // --------------------------------------------------------------- stage c1
   // signed P terms, Q terms are squares
   logic [2:0][PTW-1:0]  pt_in, pt_ff;
   logic [2:0][2*WN-1:0] qt_ff;

   always_comb begin
      logic [PTW-1:0] mv;
      mv = '0;
      for (int i = 0; i < 3; i++) begin
         mv       = PTW'(pm_mag[i]);
         pt_in[i] = pm_neg[i] ? -mv : mv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff <= pt_in;
         qt_ff <= qm_mag;
      end
   end

   // --------------------------------------------------------------- stage c2
   logic [WP-1:0]  p_ff;
   logic [WQS-1:0] q_ff;
   logic           deg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= WP'($signed(pt_ff[0])) + WP'($signed(pt_ff[1])) +
                   WP'($signed(pt_ff[2]));
         q_ff   <= WQS'(qt_ff[0]) + WQS'(qt_ff[1]) + WQS'(qt_ff[2]);
         deg_ff <= (qt_ff[0] | qt_ff[1] | qt_ff[2]) == '0;
      end
   end

   // ------------------------------------------------- P*P and N_i*P products
   logic [2*WP-1:0]       ps_mag;
   logic [2:0][WN+WP-1:0] np_mag;
   logic [2:0]            np_neg;

   ppd_mul #(.A_W(WP), .B_W(WP), .STAGES(LAT3)) u_mul_pp (
      .clock    (clock),
      .en       (en),
      .a        (p_ff),
      .b        (p_ff),
      .prod_mag (ps_mag),
      .prod_neg ()
   );

   for (genvar i = 0; i < 3; i++) begin : g_np
      ppd_mul #(.A_W(WN), .B_W(WP), .STAGES(LAT3)) u_mul_np (
         .clock    (clock),
         .en       (en),
         .a        (nd_ff[ND-1][i]),
         .b        (p_ff),
         .prod_mag (np_mag[i]),
         .prod_neg (np_neg[i])
      );
   end

   // Q waits for the products
   logic [WQS-1:0] qd_ff [LAT3];

   always_ff @(posedge clock) begin
      if (en) begin
         qd_ff[0] <= q_ff;
         for (int k = 1; k < LAT3; k++) begin
            qd_ff[k] <= qd_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------ dividers
   logic [LD-1:0]       dq;
   logic [2:0][LF-1:0]  fq;

   ppd_div #(.NUM_W(2*WP), .DEN_W(WQS), .QUO_W(LD)) u_div_dist (
      .clock (clock),
      .en    (en),
      .num   (ps_mag),
      .den   (qd_ff[LAT3-1]),
      .quo   (dq)
   );

   for (genvar i = 0; i < 3; i++) begin : g_fdiv
      ppd_div #(.NUM_W(WN+WP), .DEN_W(WQS), .QUO_W(LF)) u_div_foot (
         .clock (clock),
         .en    (en),
         .num   (np_mag[i]),
         .den   (qd_ff[LAT3-1]),
         .quo   (fq[i])
      );
   end

   // ---------------------------------------------------------- square root
   // digit by digit, one root bit per stage
   logic [SW-1:0] sq_rem_ff [WR];
   logic [SW-1:0] sq_res_ff [WR];

   for (genvar k = 0; k < WR; k++) begin : g_sqrt
      logic [SW-1:0] rem_src, res_src, bitv, trial;

      if (k == 0) begin : g_first
         assign rem_src = SW'(dq);
         assign res_src = '0;
      end else begin : g_next
         assign rem_src = sq_rem_ff[k-1];
         assign res_src = sq_res_ff[k-1];
      end

      assign bitv  = SW'(1) << (2 * (WR - 1 - k));
      assign trial = res_src + bitv;

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_src >= trial) begin
               sq_rem_ff[k] <= rem_src - trial;
               sq_res_ff[k] <= (res_src >> 1) + bitv;
            end else begin
               sq_rem_ff[k] <= rem_src;
               sq_res_ff[k] <= res_src >> 1;
            end
         end
      end
   end

   // --------------------------------------------------------- side delays
   // foot quotients wait for the distance path, signs ride alongside
   logic [2:0][LF-1:0] fqd_ff [EXTRA];
   logic [2:0]         sgd_ff [SD];
   logic               gd_ff  [GD];
   logic [2:0][W-1:0]  xd_ff  [XD];

   always_ff @(posedge clock) begin
      if (en) begin
         fqd_ff[0] <= fq;
         for (int k = 1; k < EXTRA; k++) begin
            fqd_ff[k] <= fqd_ff[k-1];
         end
         sgd_ff[0] <= np_neg;
         for (int k = 1; k < SD; k++) begin
            sgd_ff[k] <= sgd_ff[k-1];
         end
         gd_ff[0] <= deg_ff;
         for (int k = 1; k < GD; k++) begin
            gd_ff[k] <= gd_ff[k-1];
         end
         xd_ff[0] <= x_ff;
         for (int k = 1; k < XD; k++) begin
            xd_ff[k] <= xd_ff[k-1];
         end
      end
   end

   // ----------------------------------------------------------- output word
   logic [DIST_WIDTH-1:0]              dist_in, dist_ff;
   logic [2:0][FOOT_WIDTH-1:0]         foot_in, foot_ff;
   logic                               degen_ff;
   logic [DW-1:0]                      root_w;
   logic                               deg_out;

   assign deg_out = gd_ff[GD-1];
   assign root_w  = DW'(WR'(sq_res_ff[WR-1]));

   // distance saturates at the top of its range
   always_comb begin
      if (deg_out) begin
         dist_in = '0;
      end else if (root_w > DW'(DIST_MAX)) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = DIST_WIDTH'(root_w);
      end
   end

   // foot = x - signed quotient, saturated to 32 bits
   always_comb begin
      logic [FW-1:0]        qm;
      logic signed [FW-1:0] xs, diff;
      qm   = '0;
      xs   = '0;
      diff = '0;
      for (int i = 0; i < 3; i++) begin
         xs = FW'($signed(xd_ff[XD-1][i]));
         qm = FW'(fqd_ff[EXTRA-1][i]);
         if (sgd_ff[SD-1][i]) begin
            qm = -qm;
         end
         if (deg_out) begin
            qm = '0;
         end
         diff = xs - $signed(qm);
         if (diff > F_HI) begin
            foot_in[i] = FOOT_MAX;
         end else if (diff < F_LO) begin
            foot_in[i] = FOOT_MIN;
         end else begin
            foot_in[i] = FOOT_WIDTH'(diff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff  <= dist_in;
         foot_ff  <= foot_in;
         degen_ff <= deg_out;
      end
   end

   assign rsp_plane_distance   = dist_ff;
   assign rsp_foot_x           = foot_ff[0];
   assign rsp_foot_y           = foot_ff[1];
   assign rsp_foot_z           = foot_ff[2];
   assign rsp_degenerate_plane = degen_ff;

endmodule

// ===== rtl/core/ppd_mul.sv =====
module ppd_mul import ppd_pkg::*; #(
   parameter int A_W    = 33,
   parameter int B_W    = 33,
   parameter int STAGES = 5
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [A_W-1:0]       a,
   input  logic [B_W-1:0]       b,
   output logic [A_W+B_W-1:0]   prod_mag,
   output logic                 prod_neg
);

   localparam int NA     = mul_digits(A_W);
   localparam int NB     = mul_digits(B_W);
   localparam int NS     = NA * NB;
   localparam int AP_W   = NA * MUL_DIGIT;
   localparam int BP_W   = NB * MUL_DIGIT;
   localparam int ACC_W  = AP_W + BP_W;
   localparam int PP_W   = 2 * MUL_DIGIT;
   localparam int PAD    = STAGES - NS - 1;

   logic [A_W-1:0]   a_abs;
   logic [B_W-1:0]   b_abs;

   logic [AP_W-1:0]  am_ff;
   logic [BP_W-1:0]  bm_ff;
   logic             neg_ff;

   logic [AP_W-1:0]  ap_ff  [NS];
   logic [BP_W-1:0]  bp_ff  [NS];
   logic [ACC_W-1:0] acc_ff [NS];
   logic             ng_ff  [NS];

   // magnitudes at operand width, so the inversion stays inside the operand
   assign a_abs = a[A_W-1] ? (~a + A_W'(1)) : a;
   assign b_abs = b[B_W-1] ? (~b + B_W'(1)) : b;

   // two's complement operands to magnitude and sign
   always_ff @(posedge clock) begin
      if (en) begin
         am_ff  <= AP_W'(a_abs);
         bm_ff  <= BP_W'(b_abs);
         neg_ff <= a[A_W-1] ^ b[B_W-1];
      end
   end

   // one digit pair per stage, accumulated at its weight
   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int DI = s / NB;
      localparam int DJ = s % NB;
      logic [AP_W-1:0]  a_src;
      logic [BP_W-1:0]  b_src;
      logic [ACC_W-1:0] acc_src;
      logic             n_src;
      logic [PP_W-1:0]  pp;

      if (s == 0) begin : g_first
         assign a_src   = am_ff;
         assign b_src   = bm_ff;
         assign acc_src = '0;
         assign n_src   = neg_ff;
      end else begin : g_next
         assign a_src   = ap_ff[s-1];
         assign b_src   = bp_ff[s-1];
         assign acc_src = acc_ff[s-1];
         assign n_src   = ng_ff[s-1];
      end

      assign pp = PP_W'(a_src[DI*MUL_DIGIT +: MUL_DIGIT]) *
                  PP_W'(b_src[DJ*MUL_DIGIT +: MUL_DIGIT]);

      always_ff @(posedge clock) begin
         if (en) begin
            ap_ff[s]  <= a_src;
            bp_ff[s]  <= b_src;
            ng_ff[s]  <= n_src;
            acc_ff[s] <= acc_src + (ACC_W'(pp) << (MUL_DIGIT * (DI + DJ)));
         end
      end
   end

   // balance latency with sibling multipliers
   if (PAD == 0) begin : g_nopad
      assign prod_mag = acc_ff[NS-1][A_W+B_W-1:0];
      assign prod_neg = ng_ff[NS-1];
   end else begin : g_pad
      logic [A_W+B_W-1:0] pm_ff [PAD];
      logic               pn_ff [PAD];
      always_ff @(posedge clock) begin
         if (en) begin
            pm_ff[0] <= acc_ff[NS-1][A_W+B_W-1:0];
            pn_ff[0] <= ng_ff[NS-1];
            for (int k = 1; k < PAD; k++) begin
               pm_ff[k] <= pm_ff[k-1];
               pn_ff[k] <= pn_ff[k-1];
            end
         end
      end
      assign prod_mag = pm_ff[PAD-1];
      assign prod_neg = pn_ff[PAD-1];
   end

endmodule

// ===== rtl/core/ppd_div.sv =====
module ppd_div import ppd_pkg::*; #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32,
   parameter int QUO_W = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   // quotient is known to fit QUO_W bits, so restoring needs QUO_W steps
   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] q_ff   [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_step
      localparam int BIT = QUO_W - 1 - s;
      logic [NUM_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QUO_W-1:0] q_src;
      logic [CMP_W-1:0] shifted;
      logic             fits;
      logic [QUO_W-1:0] q_in;
      logic [NUM_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign q_src   = q_ff[s-1];
      end

      assign shifted = CMP_W'(den_src) << BIT;
      assign fits    = CMP_W'(rem_src) >= shifted;

      always_comb begin
         q_in      = q_src;
         q_in[BIT] = fits;
         rem_in    = fits ? NUM_W'(CMP_W'(rem_src) - shifted) : rem_src;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            q_ff[s]   <= q_in;
         end
      end
   end

   assign quo = q_ff[QUO_W-1];

endmodule

// ===== sim/ppd_checker.sv =====
`timescale 1ns / 1ps

module ppd_checker import ppd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [31:0]           req_plane_a_x,
   input  logic signed [31:0]           req_plane_a_y,
   input  logic signed [31:0]           req_plane_a_z,
   input  logic signed [31:0]           req_plane_b_x,
   input  logic signed [31:0]           req_plane_b_y,
   input  logic signed [31:0]           req_plane_b_z,
   input  logic signed [31:0]           req_plane_c_x,
   input  logic signed [31:0]           req_plane_c_y,
   input  logic signed [31:0]           req_plane_c_z,
   input  logic signed [31:0]           req_query_x,
   input  logic signed [31:0]           req_query_y,
   input  logic signed [31:0]           req_query_z,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [DIST_WIDTH-1:0]        rsp_plane_distance,
   input  logic signed [FOOT_WIDTH-1:0] rsp_foot_x,
   input  logic signed [FOOT_WIDTH-1:0] rsp_foot_y,
   input  logic signed [FOOT_WIDTH-1:0] rsp_foot_z,
   input  logic                         rsp_degenerate_plane,
   output int                           fail_count,
   output int                           pending
);

   typedef struct packed {
      logic [DIST_WIDTH-1:0]        distance;
      logic signed [FOOT_WIDTH-1:0] fx;
      logic signed [FOOT_WIDTH-1:0] fy;
      logic signed [FOOT_WIDTH-1:0] fz;
      logic                         degen;
   } ppd_result_type;

   typedef logic signed [255:0] wide_type;

   ppd_result_type expected_results[$];

   function automatic logic signed [FOOT_WIDTH-1:0] clamp_foot(input wide_type v);
      if (v > wide_type'(FOOT_MAX)) return FOOT_MAX;
      if (v < wide_type'(FOOT_MIN)) return FOOT_MIN;
      return v[FOOT_WIDTH-1:0];
   endfunction

   function automatic ppd_result_type plane_project(input wide_type a[3],
                                                    input wide_type b[3],
                                                    input wide_type c[3],
                                                    input wide_type x[3]);
      wide_type e1[3], e2[3], n[3], v[3];
      wide_type p, q, pa, sq, r, t, m;
      ppd_result_type res;
      for (int i = 0; i < 3; i++) begin
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
         v[i]  = x[i] - a[i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      p = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
      q = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      if (q == 0) begin
         res.distance = '0;
         res.fx = x[0][31:0];
         res.fy = x[1][31:0];
         res.fz = x[2][31:0];
         res.degen = 1'b1;
         return res;
      end
      pa = (p < 0) ? -p : p;
      sq = (pa * pa) / q;
      // floor sqrt by bisection, saturating at the 31-bit range
      if (sq >= wide_type'(64'h4000_0000_0000_0000)) begin
         res.distance = DIST_MAX;
      end else begin
         r = 0;
         for (int k = 31; k >= 0; k--) begin
            t = r | (wide_type'(1) << k);
            if (t * t <= sq) r = t;
         end
         res.distance = (r > wide_type'(DIST_MAX)) ? DIST_MAX : r[DIST_WIDTH-1:0];
      end
      // signed division truncates toward zero
      m = (n[0] * p) / q; res.fx = clamp_foot(x[0] - m);
      m = (n[1] * p) / q; res.fy = clamp_foot(x[1] - m);
      m = (n[2] * p) / q; res.fz = clamp_foot(x[2] - m);
      res.degen = 1'b0;
      return res;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      wide_type a[3], b[3], c[3], x[3];
      ppd_result_type got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            a[0] = req_plane_a_x; a[1] = req_plane_a_y; a[2] = req_plane_a_z;
            b[0] = req_plane_b_x; b[1] = req_plane_b_y; b[2] = req_plane_b_z;
            c[0] = req_plane_c_x; c[1] = req_plane_c_y; c[2] = req_plane_c_z;
            x[0] = req_query_x;   x[1] = req_query_y;   x[2] = req_query_z;
            expected_results.push_back(plane_project(a, b, c, x));
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_plane_distance, rsp_foot_x, rsp_foot_y, rsp_foot_z,
                    rsp_degenerate_plane};
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("ERROR: unexpected result word %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"ERROR: mismatch exp dist=%0d foot=(%0d,%0d,%0d) deg=%b",
                               " got dist=%0d foot=(%0d,%0d,%0d) deg=%b"},
                        want.distance, want.fx, want.fy, want.fz, want.degen,
                        got.distance, got.fx, got.fy, got.fz, got.degen);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== sim/tb_point_plane_distance_and_foot.sv =====
`timescale 1ns / 1ps

module tb_point_plane_distance_and_foot;
   import ppd_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] coord [12];   // a xyz, b xyz, c xyz, query xyz
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DIST_WIDTH-1:0] rsp_plane_distance;
   logic signed [FOOT_WIDTH-1:0] rsp_foot_x, rsp_foot_y, rsp_foot_z;
   logic rsp_degenerate_plane;

   int fail_count, pending;
   int idle_cycles = 0;
   logic stim_done = 1'b0;

   initial for (int i = 0; i < 12; i++) coord[i] = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   point_plane_distance_and_foot dut (
      .clock, .reset, .req_valid, .req_ready,
      .req_plane_a_x(coord[0]), .req_plane_a_y(coord[1]), .req_plane_a_z(coord[2]),
      .req_plane_b_x(coord[3]), .req_plane_b_y(coord[4]), .req_plane_b_z(coord[5]),
      .req_plane_c_x(coord[6]), .req_plane_c_y(coord[7]), .req_plane_c_z(coord[8]),
      .req_query_x(coord[9]), .req_query_y(coord[10]), .req_query_z(coord[11]),
      .rsp_valid, .rsp_ready, .rsp_plane_distance, .rsp_foot_x, .rsp_foot_y,
      .rsp_foot_z, .rsp_degenerate_plane
   );

   ppd_checker checker_i (
      .clock, .reset, .req_valid, .req_ready,
      .req_plane_a_x(coord[0]), .req_plane_a_y(coord[1]), .req_plane_a_z(coord[2]),
      .req_plane_b_x(coord[3]), .req_plane_b_y(coord[4]), .req_plane_b_z(coord[5]),
      .req_plane_c_x(coord[6]), .req_plane_c_y(coord[7]), .req_plane_c_z(coord[8]),
      .req_query_x(coord[9]), .req_query_y(coord[10]), .req_query_z(coord[11]),
      .rsp_valid, .rsp_ready, .rsp_plane_distance, .rsp_foot_x, .rsp_foot_y,
      .rsp_foot_z, .rsp_degenerate_plane, .fail_count, .pending
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // random coordinate: full range, small values or corner values
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         1, 2:    return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
         default: return $urandom;
      endcase
   endfunction

   // present one word and hold it until it is taken; valid drops only for a gap
   task automatic send_word(input logic signed [31:0] w [12]);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 12; i++) coord[i] <= w[i];
      @(posedge clock iff req_ready);
   endtask

   // response side: random back pressure, with stall-free stretches
   initial begin
      int g;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(20, 200)) @(posedge clock);
         end else begin
            g = gap_len();
            rsp_ready <= (g == 0);
            repeat (g > 0 ? g : 1) @(posedge clock);
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // watchdog: cycles with no accepted word on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic signed [31:0] w [12];
      logic signed [31:0] corner [4];
      corner[0] = 32'sh7FFFFFFF; corner[1] = 32'sh80000000;
      corner[2] = 32'sh0;        corner[3] = 32'shFFFFFFFF;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // degenerate: all points equal, all zero, collinear points
      for (int i = 0; i < 12; i++) w[i] = 32'sh0001_0000;
      w[9] = 32'sh7FFFFFFF; w[10] = 32'sh80000000; w[11] = 32'sh0;
      send_word(w);
      for (int i = 0; i < 12; i++) w[i] = 0;
      send_word(w);
      w[3] = 32'sh10000; w[4] = 32'sh10000; w[5] = 32'sh10000;
      w[6] = 32'sh20000; w[7] = 32'sh20000; w[8] = 32'sh20000;
      w[9] = 32'sh30000; w[10] = -32'sh5000;
      send_word(w);
      // plain xy plane, query above and below
      for (int i = 0; i < 12; i++) w[i] = 0;
      w[3] = 32'sh10000; w[7] = 32'sh10000;
      w[9] = 32'sh12345; w[10] = -32'sh777; w[11] = 32'sh50000;
      send_word(w);
      w[11] = -32'sh50000;
      send_word(w);
      // far query: distance at its maximum and then saturating, foot on the plane
      w[11] = 32'sh7FFFFFFF; send_word(w);
      w[11] = 32'sh80000000; send_word(w);
      // extreme plane points drive foot saturation
      for (int k = 0; k < 16; k++) begin
         for (int i = 0; i < 12; i++) w[i] = corner[$urandom_range(0, 3)];
         send_word(w);
      end

      // random words, with one pause until every expected result has drained
      for (int k = 0; k < 400; k++) begin
         if (k == 150) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         for (int i = 0; i < 12; i++) w[i] = rand_coord();
         // some coplanar-looking sets: c on line ab makes a degenerate plane
         if ($urandom_range(0, 15) == 0)
            for (int i = 0; i < 3; i++) w[6 + i] = w[3 + i];
         send_word(w);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      stim_done <= 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
